// File: hw/rtl/v3n_pkg.sv
// Shared constants for the vector normalize pipeline.
package v3n_pkg;

  localparam int unsigned FIELD_W             = 32;  // input component field width
  localparam int unsigned SUM_W               = 64;  // normalized sum of squares
  localparam int unsigned ROOT_W              = SUM_W / 2;
  localparam int unsigned K_W                 = 5;   // half shift count, 0..31
  localparam int unsigned NORM_STEPS          = 5;   // shifts by 32,16,8,4,2
  localparam int unsigned COMPONENT_WIDTH_DEF = 32;
  localparam int unsigned OUT_FRAC_BITS_DEF   = 16;

endpackage

// File: hw/rtl/v3n_if.sv
// Handshake channels for vector words and unit-vector words.
interface v3n_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [v3n_pkg::FIELD_W-1:0] comp_x;
  logic signed [v3n_pkg::FIELD_W-1:0] comp_y;
  logic signed [v3n_pkg::FIELD_W-1:0] comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface v3n_out_if #(
  parameter int unsigned OutFracBits = v3n_pkg::OUT_FRAC_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic signed [OutFracBits+1:0] unit_x;
  logic signed [OutFracBits+1:0] unit_y;
  logic signed [OutFracBits+1:0] unit_z;
  logic                     was_zero;
  modport source (output valid, unit_x, unit_y, unit_z, was_zero, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, was_zero, output ready);
endinterface

// File: hw/rtl/vector3_normalize_top.sv
// Top level of the three-component vector normalize pipeline.
// Takes one Q16.16 vector word per cycle and returns one signed Q1.F unit
// vector word per input word, in order. The stages are magnitudes and
// squares, the sum, the even normalize shift, the one-bit-per-stage square
// root, and the per-lane restoring divide plus the clamp/sign output
// register. Throughput is one word per cycle; the whole pipe holds while the
// output word is not taken, and the input is ready whenever the output
// register is empty or being drained.
// Zero vectors give zero components and was_zero set.
module vector3_normalize_top #(
  parameter int unsigned COMPONENT_WIDTH = v3n_pkg::COMPONENT_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS   = v3n_pkg::OUT_FRAC_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  v3n_in_if.sink    in_i,
  v3n_out_if.source out_o
);
  localparam int unsigned CW    = COMPONENT_WIDTH;
  localparam int unsigned SideN = 3 * CW + 3;               // mags and signs
  localparam int unsigned SideR = SideN + v3n_pkg::K_W + 1; // plus k and zero

  // global advance: pipe moves unless the output word is stalled
  logic en;
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // lanes: magnitude and square
  logic [2:0]          sq_vld;
  logic [CW-1:0]       mag [3];
  logic [2:0]          neg;
  logic [2*CW-1:0]     sq  [3];

  v3n_sq_lane #(.ComponentWidth(CW)) u_sq_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .comp_i(in_i.comp_x),
    .valid_o(sq_vld[0]), .mag_o(mag[0]), .neg_o(neg[0]), .sq_o(sq[0])
  );
  v3n_sq_lane #(.ComponentWidth(CW)) u_sq_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .comp_i(in_i.comp_y),
    .valid_o(sq_vld[1]), .mag_o(mag[1]), .neg_o(neg[1]), .sq_o(sq[1])
  );
  v3n_sq_lane #(.ComponentWidth(CW)) u_sq_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .comp_i(in_i.comp_z),
    .valid_o(sq_vld[2]), .mag_o(mag[2]), .neg_o(neg[2]), .sq_o(sq[2])
  );

  // merge: sum of squares and normalize
  logic                       nm_vld;
  logic [v3n_pkg::SUM_W-1:0]  nm_sum;
  logic [v3n_pkg::K_W-1:0]    nm_k;
  logic                       nm_zero;
  logic [SideN-1:0]           nm_side;

  v3n_norm #(.ComponentWidth(CW), .SideW(SideN)) u_norm (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld[0]),
    .sq_x_i(sq[0]), .sq_y_i(sq[1]), .sq_z_i(sq[2]),
    .side_i({neg, mag[2], mag[1], mag[0]}),
    .valid_o(nm_vld), .sum_o(nm_sum), .k_o(nm_k), .zero_o(nm_zero),
    .side_o(nm_side)
  );

  // square root of the normalized sum
  logic                       rt_vld;
  logic [v3n_pkg::ROOT_W-1:0] rt_root;
  logic [SideR-1:0]           rt_side;
  logic [CW-1:0]              rt_mag [3];
  logic [2:0]                 rt_neg;
  logic [v3n_pkg::K_W-1:0]    rt_k;
  logic                       rt_zero;

  v3n_isqrt #(.SideW(SideR)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(nm_vld), .rad_i(nm_sum),
    .side_i({nm_side, nm_k, nm_zero}),
    .valid_o(rt_vld), .root_o(rt_root), .side_o(rt_side)
  );

  assign {rt_neg, rt_mag[2], rt_mag[1], rt_mag[0], rt_k, rt_zero} = rt_side;

  // lanes: divide, round, clamp, sign
  logic [2:0]                   dv_vld;
  logic [2:0]                   dv_zero;
  logic signed [OUT_FRAC_BITS+1:0] dv_unit [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    v3n_div_lane #(.ComponentWidth(CW), .OutFracBits(OUT_FRAC_BITS)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(rt_vld),
      .mag_i(rt_mag[g]), .neg_i(rt_neg[g]), .zero_i(rt_zero), .k_i(rt_k),
      .root_i(rt_root),
      .valid_o(dv_vld[g]), .zero_o(dv_zero[g]), .unit_o(dv_unit[g])
    );
  end

  // lanes run in lockstep; lane x carries the word's valid and zero flag
  assign out_o.valid    = dv_vld[0];
  assign out_o.was_zero = dv_zero[0];
  assign out_o.unit_x   = dv_unit[0];
  assign out_o.unit_y   = dv_unit[1];
  assign out_o.unit_z   = dv_unit[2];

  localparam logic signed [OUT_FRAC_BITS+1:0] One =
    (OUT_FRAC_BITS+2)'(1) << OUT_FRAC_BITS;

  a_zero_forces_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.was_zero) |->
      (out_o.unit_x == '0 && out_o.unit_y == '0 && out_o.unit_z == '0))
    else $error("zero vector with nonzero components");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.unit_x <= One && out_o.unit_x >= -One &&
                     out_o.unit_y <= One && out_o.unit_y >= -One &&
                     out_o.unit_z <= One && out_o.unit_z >= -One))
    else $error("unit component outside +/- one");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_vld == {3{sq_vld[0]}}) && (dv_vld == {3{dv_vld[0]}}) &&
    (!dv_vld[0] || (dv_zero == {3{dv_zero[0]}})))
    else $error("lanes out of step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(dv_unit[0])))
    else $error("stalled word lost");
endmodule

// File: hw/rtl/v3n_sq_lane.sv
// One lane: magnitude, sign and square of one component.
module v3n_sq_lane #(
  parameter int unsigned ComponentWidth = v3n_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [v3n_pkg::FIELD_W-1:0]   comp_i,
  output logic                          valid_o,
  output logic [ComponentWidth-1:0]     mag_o,
  output logic                          neg_o,
  output logic [2*ComponentWidth-1:0]   sq_o
);
  logic [ComponentWidth-1:0] raw;
  logic [ComponentWidth-1:0] mag_d;
  logic                      vld_q;

  assign raw   = comp_i[ComponentWidth-1:0];
  // -2^(w-1) wraps to 2^(w-1), which still fits unsigned
  assign mag_d = raw[ComponentWidth-1] ? (~raw + 1'b1) : raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= mag_d;
      neg_o <= raw[ComponentWidth-1];
      sq_o  <= (2*ComponentWidth)'(mag_d) * (2*ComponentWidth)'(mag_d);
    end
  end

  assign valid_o = vld_q;
endmodule

// File: hw/rtl/v3n_norm.sv
// Merge stage: sum of squares, zero detect and even left shift to the top.
module v3n_norm #(
  parameter int unsigned ComponentWidth = v3n_pkg::COMPONENT_WIDTH_DEF,
  parameter int unsigned SideW          = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2*ComponentWidth-1:0] sq_x_i,
  input  logic [2*ComponentWidth-1:0] sq_y_i,
  input  logic [2*ComponentWidth-1:0] sq_z_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [v3n_pkg::SUM_W-1:0]   sum_o,
  output logic [v3n_pkg::K_W-1:0]     k_o,
  output logic                        zero_o,
  output logic [SideW-1:0]            side_o
);
  localparam int unsigned St = v3n_pkg::NORM_STEPS + 1;
  localparam int unsigned SW = v3n_pkg::SUM_W;

  logic [SW-1:0]           s_q    [St];
  logic [SW-1:0]           s_d    [St];
  logic [v3n_pkg::K_W-1:0] k_q    [St];
  logic [v3n_pkg::K_W-1:0] k_d    [St];
  logic                    z_q    [St];
  logic [SideW-1:0]        side_q [St];
  logic [St-1:0]           vld_q;

  always_comb begin
    s_d[0] = SW'(sq_x_i) + SW'(sq_y_i) + SW'(sq_z_i);
    k_d[0] = '0;
    for (int i = 1; i < St; i++) begin
      // step i shifts by 2^(6-i) bits when that many top bits are clear
      if ((s_q[i-1] >> (SW - (SW >> i))) == '0) begin
        s_d[i] = s_q[i-1] << (SW >> i);
        k_d[i] = k_q[i-1] | v3n_pkg::K_W'(1 << (v3n_pkg::K_W - i));
      end else begin
        s_d[i] = s_q[i-1];
        k_d[i] = k_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[St-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= s_d[0];
      k_q[0]    <= k_d[0];
      z_q[0]    <= (s_d[0] == '0);
      side_q[0] <= side_i;
      for (int i = 1; i < St; i++) begin
        s_q[i]    <= s_d[i];
        k_q[i]    <= k_d[i];
        z_q[i]    <= z_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[St-1];
  assign sum_o   = s_q[St-1];
  assign k_o     = k_q[St-1];
  assign zero_o  = z_q[St-1];
  assign side_o  = side_q[St-1];
endmodule

// File: hw/rtl/v3n_isqrt.sv
// Integer square root, one result bit per pipeline stage.
module v3n_isqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [v3n_pkg::SUM_W-1:0]    rad_i,
  input  logic [SideW-1:0]             side_i,
  output logic                         valid_o,
  output logic [v3n_pkg::ROOT_W-1:0]   root_o,
  output logic [SideW-1:0]             side_o
);
  localparam int unsigned St = v3n_pkg::ROOT_W;
  localparam int unsigned RW = v3n_pkg::ROOT_W;
  localparam int unsigned RemW = RW + 2;

  logic [v3n_pkg::SUM_W-1:0] rad_q  [St];
  logic [v3n_pkg::SUM_W-1:0] rad_d  [St];
  logic [RemW-1:0]           rem_q  [St];
  logic [RemW-1:0]           rem_d  [St];
  logic [RW-1:0]             root_q [St];
  logic [RW-1:0]             root_d [St];
  logic [SideW-1:0]          side_q [St];
  logic [St-1:0]             vld_q;

  always_comb begin
    logic [v3n_pkg::SUM_W-1:0] rad_s;
    logic [RemW-1:0]           rem_s;
    logic [RW-1:0]             root_s;
    logic [RemW+1:0]           cur;
    logic [RemW+1:0]           trial;
    for (int i = 0; i < St; i++) begin
      rad_s  = (i == 0) ? rad_i : rad_q[(i == 0) ? 0 : i-1];
      rem_s  = (i == 0) ? '0    : rem_q[(i == 0) ? 0 : i-1];
      root_s = (i == 0) ? '0    : root_q[(i == 0) ? 0 : i-1];
      cur    = {rem_s, rad_s[v3n_pkg::SUM_W-1 -: 2]};
      trial  = (RemW+2)'({root_s, 2'b01});
      rad_d[i] = rad_s << 2;
      if (cur >= trial) begin
        rem_d[i]  = RemW'(cur - trial);
        root_d[i] = {root_s[RW-2:0], 1'b1};
      end else begin
        rem_d[i]  = RemW'(cur);
        root_d[i] = {root_s[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[St-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < St; i++) begin
        rad_q[i]  <= rad_d[i];
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        side_q[i] <= (i == 0) ? side_i : side_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign valid_o = vld_q[St-1];
  assign root_o  = root_q[St-1];
  assign side_o  = side_q[St-1];
endmodule

// File: hw/rtl/v3n_div_lane.sv
// One lane: rounded |c|*2^k*2^F / r by restoring division, clamp and sign.
module v3n_div_lane #(
  parameter int unsigned ComponentWidth = v3n_pkg::COMPONENT_WIDTH_DEF,
  parameter int unsigned OutFracBits    = v3n_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [ComponentWidth-1:0]         mag_i,
  input  logic                              neg_i,
  input  logic                              zero_i,
  input  logic [v3n_pkg::K_W-1:0]           k_i,
  input  logic [v3n_pkg::ROOT_W-1:0]        root_i,
  output logic                              valid_o,
  output logic                              zero_o,
  output logic signed [OutFracBits+1:0]     unit_o
);
  localparam int unsigned OW = OutFracBits + 2;   // quotient and output width
  localparam int unsigned NW = OutFracBits + 35;  // 2*num + r stays below 2^(F+34)
  localparam int unsigned DW = v3n_pkg::ROOT_W + 1;
  localparam int unsigned St = OW;

  logic [NW-1:0] rem_q [St];
  logic [NW-1:0] rem_d [St];
  logic [OW-1:0] quo_q [St];
  logic [OW-1:0] quo_d [St];
  logic [DW-1:0] den_q [St];
  logic [St-1:0] neg_q;
  logic [St-1:0] zr_q;
  logic [St:0]   vld_q;

  logic [NW-1:0] numer;
  logic [DW-1:0] denom;
  logic [OW-1:0] mag_r;
  logic [OW-1:0] unit_d;

  assign numer = ((NW'(mag_i) << k_i) << (OutFracBits + 1)) + NW'(root_i);
  assign denom = {root_i, 1'b0};

  always_comb begin
    logic [NW-1:0] rem_s;
    logic [OW-1:0] quo_s;
    logic [DW-1:0] den_s;
    logic [NW-1:0] dsh;
    for (int i = 0; i < St; i++) begin
      rem_s = (i == 0) ? numer : rem_q[(i == 0) ? 0 : i-1];
      quo_s = (i == 0) ? '0    : quo_q[(i == 0) ? 0 : i-1];
      den_s = (i == 0) ? denom : den_q[(i == 0) ? 0 : i-1];
      dsh   = NW'(den_s) << (St - 1 - i);
      quo_d[i] = quo_s;
      if (rem_s >= dsh) begin
        rem_d[i] = rem_s - dsh;
        quo_d[i][St-1-i] = 1'b1;
      end else begin
        rem_d[i] = rem_s;
      end
    end
  end

  // clamp to one, then apply the sign; zero vectors are forced to zero
  always_comb begin
    mag_r = quo_q[St-1];
    if (mag_r > (OW'(1) << OutFracBits)) begin
      mag_r = OW'(1) << OutFracBits;
    end
    if (zr_q[St-1]) begin
      unit_d = '0;
    end else if (neg_q[St-1]) begin
      unit_d = ~mag_r + 1'b1;
    end else begin
      unit_d = mag_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[St-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < St; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
        den_q[i] <= (i == 0) ? denom : den_q[(i == 0) ? 0 : i-1];
      end
      neg_q  <= {neg_q[St-2:0], neg_i};
      zr_q   <= {zr_q[St-2:0], zero_i};
      unit_o <= unit_d;
      zero_o <= zr_q[St-1];
    end
  end

  assign valid_o = vld_q[St];
endmodule
